>>> rtl/core/sensor_timestamp_unit_assert.svh
// Assertion macros of the sensor timestamp unit, used by stu_ctrl.
`ifndef SENSOR_TIMESTAMP_UNIT_ASSERT_SVH
`define SENSOR_TIMESTAMP_UNIT_ASSERT_SVH

// Same-cycle implication, checked on clk while rst_n is high.
`define STU_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("stu assertion failed");

// Next-cycle implication, checked on clk while rst_n is high.
`define STU_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("stu assertion failed");

// Invariant, checked on clk while rst_n is high.
`define STU_ASSERT_ALW(label, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("stu assertion failed");

`endif

>>> rtl/core/stu_pkg.sv
// Shared types, codes and calendar helpers of the sensor timestamp unit.
package stu_pkg;

  localparam int IN_TDATA_W  = 152;
  localparam int OUT_TDATA_W = 64;

  localparam logic [1:0] MODE_HOST = 2'd0;
  localparam logic [1:0] MODE_UTC  = 2'd1;
  localparam logic [1:0] MODE_TICK = 2'd2;

  localparam logic [1:0] SRC_HOST  = 2'd0;
  localparam logic [1:0] SRC_UTC   = 2'd1;
  localparam logic [1:0] SRC_FIRST = 2'd2;
  localparam logic [1:0] SRC_ACC   = 2'd3;

  localparam logic REG_TIME_MODE     = 1'b0;
  localparam logic REG_TICK_ROLLOVER = 1'b1;

  localparam logic [62:0] STAMP_MAX = {63{1'b1}};

  typedef struct packed {
    logic       load_in;
    logic       date;
    logic       secs;
    logic       mul_lo;
    logic       mul_hi;
    logic       tk_first;
    logic       tk_diff;
    logic       tk_mul;
    logic       tk_acc;
    logic       load_out;
    logic [1:0] src;
  } cmd_t;

  typedef struct packed {
    logic [1:0] mode;
    logic       has_utc;
    logic       has_ticks;
    logic       awaiting;
  } status_t;

  // floor(x / 25) for x up to 1124
  function automatic logic [5:0] div25(input logic [10:0] x);
    logic [21:0] p;
    p = {11'b0, x} * 22'd1311;
    return p[20:15];
  endfunction

  // day of the March-based year on which the raw month starts
  function automatic logic [8:0] month_base(input logic [3:0] mon);
    logic [8:0] b;
    case (mon)
      4'd0:    b = 9'd275;
      4'd1:    b = 9'd306;
      4'd2:    b = 9'd337;
      4'd3:    b = 9'd0;
      4'd4:    b = 9'd31;
      4'd5:    b = 9'd61;
      4'd6:    b = 9'd92;
      4'd7:    b = 9'd122;
      4'd8:    b = 9'd153;
      4'd9:    b = 9'd184;
      4'd10:   b = 9'd214;
      4'd11:   b = 9'd245;
      4'd12:   b = 9'd275;
      4'd13:   b = 9'd306;
      4'd14:   b = 9'd337;
      default: b = 9'd0;
    endcase
    return b;
  endfunction

  // offset that turns the raw year into the shifted, non-negative year
  function automatic logic [8:0] year_bias(input logic [3:0] mon);
    logic [8:0] b;
    if (mon <= 4'd2) begin
      b = 9'd399;
    end else if (mon == 4'd15) begin
      b = 9'd401;
    end else begin
      b = 9'd400;
    end
    return b;
  endfunction

endpackage

>>> rtl/core/stu_ctrl.sv
// Sequencing state machine of the sensor timestamp unit.
`include "sensor_timestamp_unit_assert.svh"

module stu_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  output logic             out_tvalid,
  input  logic             out_tready,
  input  stu_pkg::status_t status,
  output stu_pkg::cmd_t    cmd
);
  import stu_pkg::*;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_DISP   = 4'd1;
  localparam logic [3:0] S_DATE   = 4'd2;
  localparam logic [3:0] S_SECS   = 4'd3;
  localparam logic [3:0] S_MLO    = 4'd4;
  localparam logic [3:0] S_MHI    = 4'd5;
  localparam logic [3:0] S_TFIRST = 4'd6;
  localparam logic [3:0] S_TDIFF  = 4'd7;
  localparam logic [3:0] S_TMUL   = 4'd8;
  localparam logic [3:0] S_TACC   = 4'd9;
  localparam logic [3:0] S_FIN    = 4'd10;

  logic [3:0] state_r, state_nxt;
  logic [1:0] src_r, src_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic [8:0] step_cmd;

  assign in_tready  = rst_n && (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    src_nxt       = src_r;
    out_valid_nxt = out_valid_r && !out_tready;
    cmd           = '0;
    cmd.src       = src_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.load_in = 1'b1;
          state_nxt   = S_DISP;
        end
      end
      S_DISP: begin
        if (status.mode == MODE_UTC && status.has_utc) begin
          src_nxt   = SRC_UTC;
          state_nxt = S_DATE;
        end else if (status.mode == MODE_TICK && status.has_ticks) begin
          if (status.awaiting) begin
            src_nxt   = SRC_FIRST;
            state_nxt = S_TFIRST;
          end else begin
            src_nxt   = SRC_ACC;
            state_nxt = S_TDIFF;
          end
        end else begin
          src_nxt   = SRC_HOST;
          state_nxt = S_FIN;
        end
      end
      S_DATE: begin
        cmd.date  = 1'b1;
        state_nxt = S_SECS;
      end
      S_SECS: begin
        cmd.secs  = 1'b1;
        state_nxt = S_MLO;
      end
      S_MLO: begin
        cmd.mul_lo = 1'b1;
        state_nxt  = S_MHI;
      end
      S_MHI: begin
        cmd.mul_hi = 1'b1;
        state_nxt  = S_FIN;
      end
      S_TFIRST: begin
        cmd.tk_first = 1'b1;
        state_nxt    = S_FIN;
      end
      S_TDIFF: begin
        cmd.tk_diff = 1'b1;
        state_nxt   = S_TMUL;
      end
      S_TMUL: begin
        cmd.tk_mul = 1'b1;
        state_nxt  = S_TACC;
      end
      S_TACC: begin
        cmd.tk_acc = 1'b1;
        state_nxt  = S_FIN;
      end
      S_FIN: begin
        if (!out_valid_r || out_tready) begin
          cmd.load_out  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      src_r       <= SRC_HOST;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      src_r       <= src_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign step_cmd = {cmd.date, cmd.secs, cmd.mul_lo, cmd.mul_hi, cmd.tk_first, cmd.tk_diff,
                     cmd.tk_mul, cmd.tk_acc, cmd.load_out};

  `STU_ASSERT_IMP(a_load_free, cmd.load_out, (!out_valid_r || out_tready))
  `STU_ASSERT_NXT(a_accept_disp, (in_tvalid && in_tready), (state_r == S_DISP))
  `STU_ASSERT_NXT(a_lo_then_hi, cmd.mul_lo, cmd.mul_hi)
  `STU_ASSERT_IMP(a_utc_src, (state_r == S_MLO), (src_r == SRC_UTC))
  `STU_ASSERT_ALW(a_cmd_excl, $onehot0(step_cmd))

endmodule

>>> rtl/core/stu_dp.sv
// Datapath of the sensor timestamp unit: registers, calendar and tick arithmetic.
module stu_dp (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_valid,
  input  logic                             cfg_index,
  input  logic [31:0]                      cfg_data,
  input  logic [stu_pkg::IN_TDATA_W-1:0]   in_tdata,
  input  logic [1:0]                       in_tuser,
  input  stu_pkg::cmd_t                    cmd,
  output stu_pkg::status_t                 status,
  output logic [stu_pkg::OUT_TDATA_W-1:0]  out_tdata,
  output logic [1:0]                       out_tuser
);
  import stu_pkg::*;

  localparam logic signed [22:0] DAY_BIAS = 23'sd865566;
  localparam logic signed [40:0] SECS_HI  = 41'sd9223372030;
  localparam logic signed [40:0] SECS_LO  = -41'sd10;
  localparam logic signed [63:0] TEN_SEC  = 64'sd10000000000;

  // configuration and persistent state
  logic [1:0]  mode_r;
  logic [31:0] roll_r;
  logic [62:0] acc_r;
  logic [31:0] prev_r;
  logic        await_r;

  // request fields
  logic        has_utc_r, has_ticks_r;
  logic [11:0] year_r;
  logic [3:0]  mon_r;
  logic [4:0]  day_r;
  logic [4:0]  hour_r;
  logic [5:0]  min_r;
  logic [5:0]  sec_r;
  logic [13:0] tenth_r;
  logic [31:0] ticks_r;
  logic [62:0] host_r;

  // working registers
  logic signed [22:0] days_r;
  logic [16:0]        tod_r;
  logic [30:0]        frac_r;
  logic               sat_hi_r, sat_lo_r;
  logic [33:0]        off_r;
  logic signed [63:0] utc_acc_r;
  logic signed [33:0] diff_r;
  logic signed [51:0] delta_r;
  logic [62:0]        out_stamp_r;
  logic [1:0]         out_src_r;

  logic [12:0]        yy;
  logic [10:0]        q;
  logic [21:0]        yy365;
  logic [5:0]         d25a, d25b;
  logic signed [22:0] days_c;
  logic [16:0]        tod_c;
  logic [30:0]        frac_c;
  logic signed [40:0] secs_c;
  logic [46:0]        lo_prod, hi_prod;
  logic [62:0]        utc_stamp;
  logic signed [33:0] diff_c;
  logic signed [64:0] sum_c;
  logic [62:0]        acc_c;

  assign status.mode      = mode_r;
  assign status.has_utc   = has_utc_r;
  assign status.has_ticks = has_ticks_r;
  assign status.awaiting  = await_r;

  // calendar to day count, seconds of day and sub-second nanoseconds
  always_comb begin
    yy     = {1'b0, year_r} + {4'b0, year_bias(mon_r)};
    q      = yy[12:2];
    yy365  = {9'b0, yy} * 22'd365;
    d25a   = div25(q);
    d25b   = div25({2'b0, q[10:2]});
    days_c = $signed({1'b0, yy365}) + $signed({12'b0, q}) - $signed({17'b0, d25a})
           + $signed({17'b0, d25b}) + $signed({14'b0, month_base(mon_r)})
           + $signed({18'b0, day_r}) - DAY_BIAS;
    tod_c  = {12'b0, hour_r} * 17'd3600 + {11'b0, min_r} * 17'd60 + {11'b0, sec_r};
    frac_c = {17'b0, tenth_r} * 31'd100000;
  end

  assign secs_c  = $signed({{18{days_r[22]}}, days_r}) * 41'sd86400
                 + $signed({24'b0, tod_r});
  assign lo_prod = {30'b0, off_r[16:0]} * 47'd1000000000;
  assign hi_prod = {30'b0, off_r[33:17]} * 47'd1000000000;

  always_comb begin
    if (sat_hi_r) begin
      utc_stamp = STAMP_MAX;
    end else if (sat_lo_r || utc_acc_r[63]) begin
      utc_stamp = '0;
    end else begin
      utc_stamp = utc_acc_r[62:0];
    end
  end

  // tick difference with wrap correction
  always_comb begin
    diff_c = $signed({2'b0, ticks_r}) - $signed({2'b0, prev_r});
    if (diff_c < -$signed({3'b0, roll_r[31:1]})) begin
      diff_c = diff_c + $signed({2'b0, roll_r});
    end
  end

  // saturating accumulate
  always_comb begin
    sum_c = $signed({2'b0, acc_r}) + $signed({{13{delta_r[51]}}, delta_r});
    if (sum_c[64]) begin
      acc_c = '0;
    end else if (sum_c[63]) begin
      acc_c = STAMP_MAX;
    end else begin
      acc_c = sum_c[62:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_HOST;
      roll_r  <= 32'hFFFF_FFFF;
      acc_r   <= '0;
      prev_r  <= '0;
      await_r <= 1'b1;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          REG_TIME_MODE:     mode_r <= cfg_data[1:0];
          REG_TICK_ROLLOVER: roll_r <= cfg_data;
          default:           mode_r <= mode_r;
        endcase
      end
      if (cmd.tk_first) begin
        acc_r   <= host_r;
        prev_r  <= ticks_r;
        await_r <= 1'b0;
      end
      if (cmd.tk_acc) begin
        acc_r  <= acc_c;
        prev_r <= ticks_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      has_utc_r   <= in_tuser[0];
      has_ticks_r <= in_tuser[1];
      year_r      <= in_tdata[11:0];
      mon_r       <= in_tdata[15:12];
      day_r       <= in_tdata[20:16];
      hour_r      <= in_tdata[25:21];
      min_r       <= in_tdata[31:26];
      sec_r       <= in_tdata[37:32];
      tenth_r     <= in_tdata[51:38];
      ticks_r     <= in_tdata[83:52];
      host_r      <= in_tdata[146:84];
    end
    if (cmd.date) begin
      days_r <= days_c;
      tod_r  <= tod_c;
      frac_r <= frac_c;
    end
    if (cmd.secs) begin
      sat_hi_r <= (secs_c > SECS_HI);
      sat_lo_r <= (secs_c < SECS_LO);
      off_r    <= secs_c[33:0] + 34'd10;
    end
    if (cmd.mul_lo) begin
      utc_acc_r <= $signed({17'b0, lo_prod}) + $signed({33'b0, frac_r}) - TEN_SEC;
    end
    if (cmd.mul_hi) begin
      utc_acc_r <= utc_acc_r + $signed({hi_prod[46:0], 17'b0});
    end
    if (cmd.tk_diff) begin
      diff_r <= diff_c;
    end
    if (cmd.tk_mul) begin
      delta_r <= $signed({{18{diff_r[33]}}, diff_r}) * 52'sd100000;
    end
    if (cmd.load_out) begin
      out_src_r <= cmd.src;
      case (cmd.src)
        SRC_HOST:  out_stamp_r <= host_r;
        SRC_UTC:   out_stamp_r <= utc_stamp;
        SRC_FIRST: out_stamp_r <= acc_r;
        default:   out_stamp_r <= acc_r;
      endcase
    end
  end

  assign out_tdata = {1'b0, out_stamp_r};
  assign out_tuser = out_src_r;

endmodule

>>> rtl/core/sensor_timestamp_unit.sv
// Top level of the sensor timestamp unit: controller and datapath.
// After accept a request runs dispatch, then its mode's states, then the result load:
// host pass-through none, first tick latch TFIRST, tick accumulation TDIFF, TMUL, TACC, UTC
// DATE, SECS, MLO, MHI; after the load a new request is taken while a result waits.
// Synchronous active-low reset: host mode, full rollover, accumulator and tick count zero,
// next tick request latches host time; no clearing pass.
module sensor_timestamp_unit (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic                             cfg_index,
  input  logic [31:0]                      cfg_data,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // utc_year, utc_month, utc_day, utc_hour, utc_minute, utc_second, utc_tenth_ms,
  // sample_ticks, host_time_ns, zero pad
  input  logic [stu_pkg::IN_TDATA_W-1:0]   in_tdata,
  // has_utc, has_ticks
  input  logic [1:0]                       in_tuser,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // stamp_ns, zero pad
  output logic [stu_pkg::OUT_TDATA_W-1:0]  out_tdata,
  // stamp_source
  output logic [1:0]                       out_tuser
);
  import stu_pkg::*;

  cmd_t    cmd;
  status_t status;

  assign cfg_ready = rst_n;

  stu_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .status     (status),
    .cmd        (cmd)
  );

  stu_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .cmd       (cmd),
    .status    (status),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

endmodule

>>> dv/tb_sensor_timestamp_unit.sv
`timescale 1ns / 1ps
// Self-checking testbench of the sensor timestamp unit: directed table, then random streams.
module tb_sensor_timestamp_unit;
  import stu_pkg::*;

  localparam int unsigned LIMIT = 400000;
  localparam longint SMAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic [1:0] MODE_SPARE = 2'd3;
  localparam logic [31:0] ROLL_FULL = 32'hFFFF_FFFF;
  localparam logic [62:0] LATCH_NS = STAMP_MAX - (63'd1 << 48);

  typedef struct {
    logic        has_utc;
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
    logic [13:0] tenth;
    logic        has_ticks;
    logic [31:0] ticks;
    logic [62:0] host;
  } pkt_t;

  typedef struct {
    logic [62:0] ns;
    logic [1:0]  src;
  } stamp_t;

  typedef struct {
    logic [1:0]  mode;
    logic [31:0] roll;
    pkt_t        pkt;
    bit          typed;
    stamp_t      want;
  } row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic cfg_index = 1'b0;
  logic [31:0] cfg_data = '0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_TDATA_W-1:0] in_tdata = '0;
  logic [1:0] in_tuser = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic [1:0] out_tuser;

  logic [1:0]  mode_reg = MODE_HOST;
  logic [31:0] roll_reg = ROLL_FULL;
  logic [62:0] acc_ns = '0;
  logic [31:0] prev_tk = '0;
  bit          first_pending = 1'b1;
  logic [31:0] last_tk = '0;

  stamp_t stamp_q[$];
  stamp_t head;
  row_t   dir_tab[$];
  int errors = 0;
  int results_seen = 0;
  int send_pct = 20;
  int stall_pct = 20;
  bit pressure_done = 1'b0;
  int unsigned cycles = 0;

  sensor_timestamp_unit DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("ERROR at %0t: %s got %0h want %0h", $time, what, got, want);
    errors++;
  endtask

  function automatic logic [62:0] calendar_ns(pkt_t p);
    longint y, m, d, hh, mm, ss, fr, ys, cyc, yin, mar, dy, days, secs, total;
    y = longint'(p.year);
    m = longint'(p.month) - 1;
    d = longint'(p.day);
    hh = longint'(p.hour);
    mm = longint'(p.minute);
    ss = longint'(p.second);
    fr = longint'(p.tenth);
    if (m < 0) begin
      m += 12;
      y -= 1;
    end
    if (m >= 12) begin
      m -= 12;
      y += 1;
    end
    ys = (m < 2) ? y + 399 : y + 400;
    cyc = ys / 400;
    yin = ys - cyc * 400;
    mar = (m >= 2) ? m - 2 : m + 10;
    dy = (153 * mar + 2) / 5 + d - 1;
    days = cyc * 146097 + yin * 365 + yin / 4 - yin / 100 + dy - 719468 - 146097;
    secs = days * 86400 + hh * 3600 + mm * 60 + ss;
    if (secs > 64'sd9223372030) return STAMP_MAX;
    if (secs < -10) return '0;
    total = secs * 1000000000 + fr * 100000;
    if (total < 0) return '0;
    return total[62:0];
  endfunction

  function automatic stamp_t predict_stamp(pkt_t p);
    stamp_t r;
    longint diff, half, acc, delta;
    r.ns = p.host;
    r.src = SRC_HOST;
    if (mode_reg == MODE_UTC && p.has_utc) begin
      r.ns = calendar_ns(p);
      r.src = SRC_UTC;
    end else if (mode_reg == MODE_TICK && p.has_ticks) begin
      if (first_pending) begin
        first_pending = 1'b0;
        acc_ns = p.host;
        r.src = SRC_FIRST;
      end else begin
        diff = longint'({32'b0, p.ticks}) - longint'({32'b0, prev_tk});
        half = longint'({32'b0, roll_reg}) / 2;
        acc = longint'({1'b0, acc_ns});
        if (diff < -half) diff += longint'({32'b0, roll_reg});
        delta = diff * 100000;
        if (delta > 0 && acc > SMAX - delta) begin
          acc = SMAX;
        end else begin
          acc += delta;
          if (acc < 0) acc = 0;
        end
        acc_ns = acc[62:0];
        r.src = SRC_ACC;
      end
      prev_tk = p.ticks;
      r.ns = acc_ns;
    end
    return r;
  endfunction

  function automatic void add_row(logic [1:0] mode, logic [31:0] roll, int hu, int y, int mo,
                                  int d, int h, int mi, int s, int t, int ht, logic [31:0] tk,
                                  logic [62:0] host, int typed, logic [62:0] ns, logic [1:0] src);
    row_t r;
    r.mode = mode;
    r.roll = roll;
    r.pkt.has_utc = 1'(hu);
    r.pkt.year = 12'(y);
    r.pkt.month = 4'(mo);
    r.pkt.day = 5'(d);
    r.pkt.hour = 5'(h);
    r.pkt.minute = 6'(mi);
    r.pkt.second = 6'(s);
    r.pkt.tenth = 14'(t);
    r.pkt.has_ticks = 1'(ht);
    r.pkt.ticks = tk;
    r.pkt.host = host;
    r.typed = 1'(typed);
    r.want.ns = ns;
    r.want.src = src;
    dir_tab.push_back(r);
  endfunction

  function automatic pkt_t random_pkt();
    pkt_t p;
    logic [32:0] nxt;
    int pick;
    p.has_utc = $urandom_range(0, 9) != 0;
    p.has_ticks = $urandom_range(0, 9) != 0;
    if ($urandom_range(0, 9) == 0) begin
      p.year = 12'($urandom);
      p.month = 4'($urandom);
      p.day = 5'($urandom);
      p.hour = 5'($urandom);
      p.minute = 6'($urandom);
      p.second = 6'($urandom);
      p.tenth = 14'($urandom);
    end else begin
      p.year = 12'($urandom_range(1970, 2099));
      p.month = 4'($urandom_range(1, 12));
      p.day = 5'($urandom_range(1, 31));
      p.hour = 5'($urandom_range(0, 23));
      p.minute = 6'($urandom_range(0, 59));
      p.second = 6'($urandom_range(0, 60));
      p.tenth = 14'($urandom_range(0, 9999));
    end
    p.host = 63'({$urandom, $urandom});
    pick = $urandom_range(0, 9);
    if (pick >= 8 || roll_reg < 2) begin
      p.ticks = $urandom;
    end else if (pick == 7) begin
      p.ticks = last_tk - $urandom_range(1, 64);
    end else if (pick == 6) begin
      p.ticks = roll_reg - $urandom_range(1, 4);
    end else begin
      nxt = {1'b0, last_tk} + $urandom_range(0, 5000);
      if (nxt >= {1'b0, roll_reg}) nxt -= {1'b0, roll_reg};
      p.ticks = nxt[31:0];
    end
    if (p.has_ticks) last_tk = p.ticks;
    return p;
  endfunction

  task automatic write_reg(logic idx, logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    if (idx == REG_TIME_MODE) mode_reg = data[1:0];
    else roll_reg = data;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_idle();
    while (stamp_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic send_req(pkt_t p);
    in_tvalid <= 1'b1;
    in_tdata <= {5'b0, p.host, p.ticks, p.tenth, p.second, p.minute, p.hour, p.day, p.month,
                 p.year};
    in_tuser <= {p.has_ticks, p.has_utc};
    do @(posedge clk); while (!in_tready);
    stamp_q.push_back(predict_stamp(p));
  endtask

  task automatic idle_gap();
    if (send_pct != 0 && $urandom_range(0, 99) < send_pct) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      results_seen++;
      if (stamp_q.size() == 0) begin
        report_mismatch("result with nothing pending", out_tdata, '0);
      end else begin
        head = stamp_q.pop_front();
        if (out_tdata !== {1'b0, head.ns})
          report_mismatch("stamp_ns", out_tdata, {1'b0, head.ns});
        if (out_tuser !== head.src)
          report_mismatch("stamp_source", 64'(out_tuser), 64'(head.src));
      end
    end
  end

  initial begin
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (!pressure_done && results_seen >= 400) begin
        out_tready <= 1'b0;
        repeat (300) @(posedge clk);
        pressure_done = 1'b1;
      end else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end else begin
        out_tready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  initial begin
    row_t r;
    pkt_t p;
    int waited;
    logic [1:0] m;
    logic [31:0] rl;

    add_row(MODE_HOST, ROLL_FULL, 1, 2099, 12, 31, 23, 59, 60, 9999, 1, '1, STAMP_MAX,
            1, STAMP_MAX, SRC_HOST);
    add_row(MODE_HOST, ROLL_FULL, 0, 0, 0, 0, 0, 0, 0, 0, 0, '0, '0, 1, '0, SRC_HOST);
    add_row(MODE_UTC, ROLL_FULL, 1, 1970, 1, 1, 0, 0, 0, 0, 0, '0, 63'd5, 1, '0, SRC_UTC);
    add_row(MODE_UTC, ROLL_FULL, 1, 2099, 12, 31, 23, 59, 60, 9999, 1, '0, 63'd5,
            0, '0, SRC_UTC);
    add_row(MODE_UTC, ROLL_FULL, 0, 2020, 6, 1, 0, 0, 0, 0, 1, '0, 63'd123456789,
            1, 63'd123456789, SRC_HOST);
    add_row(MODE_UTC, ROLL_FULL, 1, 0, 0, 0, 0, 0, 0, 0, 0, '0, 63'd9, 1, '0, SRC_UTC);
    add_row(MODE_UTC, ROLL_FULL, 1, 4095, 15, 31, 31, 63, 63, 16383, 0, '0, '0,
            1, STAMP_MAX, SRC_UTC);
    add_row(MODE_UTC, ROLL_FULL, 1, 1971, 0, 0, 24, 60, 60, 10000, 0, '0, '0, 0, '0, SRC_UTC);
    add_row(MODE_UTC, ROLL_FULL, 1, 1969, 12, 31, 23, 59, 59, 16383, 0, '0, '0,
            0, '0, SRC_UTC);
    add_row(MODE_UTC, ROLL_FULL, 1, 1969, 12, 31, 23, 59, 50, 0, 0, '0, '0, 1, '0, SRC_UTC);
    add_row(MODE_UTC, ROLL_FULL, 1, 2000, 2, 29, 12, 0, 0, 5000, 0, '0, '0, 0, '0, SRC_UTC);
    add_row(MODE_SPARE, ROLL_FULL, 1, 2000, 1, 1, 0, 0, 0, 0, 1, 32'd7, 63'd42,
            1, 63'd42, SRC_HOST);
    add_row(MODE_TICK, ROLL_FULL, 1, 2000, 1, 1, 0, 0, 0, 0, 0, 32'd7, 63'd77,
            1, 63'd77, SRC_HOST);
    add_row(MODE_TICK, ROLL_FULL, 0, 0, 0, 0, 0, 0, 0, 0, 1, 32'hFFFF_FFF0, LATCH_NS,
            1, LATCH_NS, SRC_FIRST);
    add_row(MODE_TICK, ROLL_FULL, 0, 0, 0, 0, 0, 0, 0, 0, 1, 32'h10, '0, 0, '0, SRC_ACC);
    add_row(MODE_TICK, ROLL_FULL, 0, 0, 0, 0, 0, 0, 0, 0, 1, 32'h5, '0, 0, '0, SRC_ACC);
    add_row(MODE_TICK, ROLL_FULL, 1, 2000, 1, 1, 0, 0, 0, 0, 1, 32'h7FFF_FFFF, '0,
            0, '0, SRC_ACC);
    add_row(MODE_TICK, ROLL_FULL, 0, 0, 0, 0, 0, 0, 0, 0, 1, 32'hFFFF_FFFF, '0,
            1, STAMP_MAX, SRC_ACC);
    add_row(MODE_TICK, 32'd0, 0, 0, 0, 0, 0, 0, 0, 0, 1, 32'd0, '0, 0, '0, SRC_ACC);
    add_row(MODE_TICK, 32'd1, 0, 0, 0, 0, 0, 0, 0, 0, 1, 32'd5, '0, 0, '0, SRC_ACC);
    add_row(MODE_TICK, 32'd1, 0, 0, 0, 0, 0, 0, 0, 0, 1, 32'd3, '0, 0, '0, SRC_ACC);
    add_row(MODE_TICK, 32'd2, 0, 0, 0, 0, 0, 0, 0, 0, 1, 32'd1, '0, 0, '0, SRC_ACC);
    add_row(MODE_HOST, ROLL_FULL, 1, 2050, 7, 4, 1, 2, 3, 4, 1, 32'd9, 63'h2AAA_5555_0F0F_F0F0,
            1, 63'h2AAA_5555_0F0F_F0F0, SRC_HOST);

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_tab[i]) begin
      r = dir_tab[i];
      if (r.mode != mode_reg || r.roll != roll_reg) begin
        in_tvalid <= 1'b0;
        wait_idle();
        if (r.mode != mode_reg) write_reg(REG_TIME_MODE, {30'b0, r.mode});
        if (r.roll != roll_reg) write_reg(REG_TICK_ROLLOVER, r.roll);
      end
      send_req(r.pkt);
      if (r.typed) stamp_q[stamp_q.size() - 1] = r.want;
      idle_gap();
    end

    last_tk = prev_tk;
    for (int ph = 0; ph < 8; ph++) begin
      in_tvalid <= 1'b0;
      wait_idle();
      case ($urandom_range(0, 9)) inside
        0:       m = MODE_HOST;
        1:       m = MODE_SPARE;
        [2:4]:   m = MODE_UTC;
        default: m = MODE_TICK;
      endcase
      case ($urandom_range(0, 7))
        0:       rl = 32'd0;
        1:       rl = 32'd1;
        2:       rl = 32'd2;
        3:       rl = ROLL_FULL;
        4:       rl = 32'd10000;
        5:       rl = 32'h8000_0000;
        default: rl = $urandom_range(2, 32'hFFFF_FFFF);
      endcase
      write_reg(REG_TIME_MODE, {30'b0, m});
      write_reg(REG_TICK_ROLLOVER, rl);
      if (ph == 7) begin
        send_pct = 0;
        stall_pct = 0;
      end else begin
        send_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(10, 40);
        stall_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(10, 40);
      end
      for (int k = 0; k < 240; k++) begin
        p = random_pkt();
        send_req(p);
        idle_gap();
      end
    end

    in_tvalid <= 1'b0;
    waited = 0;
    while (stamp_q.size() != 0 && waited < 10000) begin
      @(posedge clk);
      waited++;
    end
    repeat (20) @(posedge clk);
    if (stamp_q.size() != 0) report_mismatch("results never arrived", 64'(stamp_q.size()), '0);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
